[src/fcme_pkg.sv]
// shared types and constants for the face centroid and min edge block
package fcme_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned SQ_W    = 64;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_FACE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EDGE,
        ST_CLOSE,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec;

endpackage

[src/fcme_store.sv]
// vertex coordinate memory with one write port and one registered read port
module fcme_store #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  fcme_pkg::t_vec i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output fcme_pkg::t_vec o_rdata
);

    fcme_pkg::t_vec r_mem [DEPTH];
    fcme_pkg::t_vec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/fcme_sqlen.sv]
// squared distance between two vertices, one axis per cycle, saturating
module fcme_sqlen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  fcme_pkg::t_vec              i_a,
    input  fcme_pkg::t_vec              i_b,
    output logic                        o_done,
    output logic [fcme_pkg::SQ_W-1:0]   o_sq
);

    logic [1:0]                  r_axis, n_axis;
    logic                        r_busy, n_busy;
    logic [fcme_pkg::SQ_W-1:0]   r_acc, n_acc;
    logic [fcme_pkg::COORD_W:0]  r_mag, n_mag;
    logic                        r_mv;
    logic signed [fcme_pkg::COORD_W:0] w_d;
    logic [fcme_pkg::SQ_W+1:0]   w_prod;
    logic [fcme_pkg::SQ_W:0]     w_sum;
    logic signed [fcme_pkg::COORD_W-1:0] w_a, w_b;

    always_comb begin
        case (r_axis)
            2'd0:    begin w_a = i_a.x; w_b = i_b.x; end
            2'd1:    begin w_a = i_a.y; w_b = i_b.y; end
            default: begin w_a = i_a.z; w_b = i_b.z; end
        endcase
        w_d    = {w_a[fcme_pkg::COORD_W-1], w_a} - {w_b[fcme_pkg::COORD_W-1], w_b};
        n_mag  = w_d[fcme_pkg::COORD_W] ? (fcme_pkg::COORD_W+1)'(-w_d)
                                       : (fcme_pkg::COORD_W+1)'(w_d);
        w_prod = r_mag * r_mag;
        w_sum  = {1'b0, r_acc} + {1'b0, w_prod[fcme_pkg::SQ_W-1:0]};
        n_acc  = r_acc;
        if (i_start) begin
            n_acc = '0;
        end else if (r_mv) begin
            n_acc = (w_sum[fcme_pkg::SQ_W] || (|w_prod[fcme_pkg::SQ_W+1:fcme_pkg::SQ_W]))
                    ? '1 : w_sum[fcme_pkg::SQ_W-1:0];
        end
        n_busy = r_busy;
        n_axis = r_axis;
        if (i_start) begin
            n_busy = 1'b1;
            n_axis = 2'd0;
        end else if (r_busy) begin
            n_axis = r_axis + 2'd1;
            if (r_axis == 2'd2) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_axis <= '0;
            r_mv   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_axis <= n_axis;
            r_mv   <= r_busy;
            o_done <= r_mv && !r_busy;
        end
        r_acc <= n_acc;
        r_mag <= n_mag;
    end

    assign o_sq = r_acc;

endmodule

[src/fcme_divroot.sv]
// shared restoring divider and integer square root, one bit per cycle
module fcme_divroot (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_div_start,
    input  logic signed [39:0]         i_num,
    input  logic [6:0]                 i_den,
    input  logic                       i_root_start,
    input  logic [fcme_pkg::SQ_W-1:0]  i_rad,
    output logic                       o_done,
    output logic [fcme_pkg::COORD_W-1:0] o_res
);

    logic                 r_busy, r_root, r_neg;
    logic [5:0]           r_cnt;
    logic [65:0]          r_rem;
    logic [63:0]          r_q;
    logic [63:0]          r_n;
    logic [6:0]           r_den;
    logic [65:0]          w_trial;
    logic [65:0]          w_rem_sh;
    logic [39:0]          w_abs;
    logic [31:0]          w_root;

    assign w_abs = i_num[39] ? 40'(-i_num) : 40'(i_num);

    always_comb begin
        if (r_root) begin
            w_rem_sh = {r_rem[63:0], r_n[63:62]};
            w_trial  = w_rem_sh - {r_q[63:0], 2'b01};
        end else begin
            w_rem_sh = {r_rem[64:0], r_n[63]};
            w_trial  = w_rem_sh - 66'(r_den);
        end
        w_root = r_q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_div_start || i_root_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_div_start) begin
            r_root <= 1'b0;
            r_neg  <= i_num[39];
            r_n    <= {w_abs, 24'd0};
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= 6'd39;
        end else if (i_root_start) begin
            r_root <= 1'b1;
            r_neg  <= 1'b0;
            r_n    <= i_rad;
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= 6'd31;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_root) begin
                r_n <= {r_n[61:0], 2'b00};
            end else begin
                r_n <= {r_n[62:0], 1'b0};
            end
            if (!w_trial[65]) begin
                r_rem <= w_trial;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_res = r_root ? w_root : (r_neg ? 32'(-r_q[31:0]) : r_q[31:0]);

endmodule

[src/face_centroid_min_edge_top.sv]
// top level: vertex store, face accumulator and shared divide/root unit
//
//  channel | handshake        | beat fields
//  in      | i_valid, o_ready | i_operation i_vertex_index i_coord_x/y/z i_last_of_face
//  out     | o_valid, i_ready | o_center_x/y/z o_min_edge_length o_vertex_count
//          |                  | o_too_many_vertices
//
// a load is written straight to the store; a face vertex reads the store, then runs the squared-length
// unit, which is skipped when it forms no edge (first vertex of a face or one past the limit)
// a closing vertex then runs the closing edge, the three divides and the root, and moves the
// result to the output register
// synchronous active-low reset clears control and face state; the store is not cleared
// input stalls while a face is processed and while a finished face waits for the output
module face_centroid_min_edge_top #(
    parameter int unsigned VERTEX_DEPTH   = 4096,
    parameter int unsigned MAX_FACE_VERTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_operation,
    input  logic [12:0]  i_vertex_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic         i_last_of_face,
    output logic         o_valid,
    input  logic         i_ready,
    output logic signed [31:0] o_center_x,
    output logic signed [31:0] o_center_y,
    output logic signed [31:0] o_center_z,
    output logic [31:0]  o_min_edge_length,
    output logic [4:0]   o_vertex_count,
    output logic         o_too_many_vertices
);

    localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int unsigned XW = (AW > 13) ? AW + 1 : 14;
    localparam int unsigned CW = $clog2(MAX_FACE_VERTS + 1);

    fcme_pkg::t_state r_state, n_state;

    logic [XW-1:0]    w_addr;
    logic             w_inrange;
    logic             w_acc;
    logic             w_out_free;
    logic             r_valid_v, r_last;
    fcme_pkg::t_vec   w_rdata, r_v, r_first, r_prev, w_sa, w_sb, w_zero;
    logic signed [39:0] r_sum [3];
    logic [63:0]      r_min;
    logic [CW-1:0]    r_cnt;
    logic             r_ovf;
    logic             w_sq_start, w_sq_done;
    logic [63:0]      w_sq;
    logic             w_div_start, w_root_start, w_dr_done;
    logic [31:0]      w_dr_res;
    logic [31:0]      r_res_x, r_res_y, r_res_z, r_res_len;
    logic [1:0]       r_axis;
    logic             r_launched;
    logic             r_use_edge;

    assign w_zero     = '0;
    assign w_addr     = XW'(i_vertex_index) - XW'(1);
    assign w_inrange  = (w_addr < XW'(VERTEX_DEPTH));
    assign o_ready    = (r_state == fcme_pkg::ST_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_out_free = !o_valid || i_ready;

    fcme_store #(.DEPTH(VERTEX_DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && (i_operation == fcme_pkg::OP_LOAD) && w_inrange),
        .i_waddr (w_addr[AW-1:0]),
        .i_wdata ({i_coord_x, i_coord_y, i_coord_z}),
        .i_re    (w_acc && (i_operation == fcme_pkg::OP_FACE)),
        .i_raddr (w_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_sa = (r_state == fcme_pkg::ST_CLOSE) ? r_first : r_prev;
    assign w_sb = (r_state == fcme_pkg::ST_CLOSE) ? r_prev : r_v;

    fcme_sqlen u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_a     (w_sa),
        .i_b     (w_sb),
        .o_done  (w_sq_done),
        .o_sq    (w_sq)
    );

    fcme_divroot u_dr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_div_start  (w_div_start),
        .i_num        (r_sum[r_axis]),
        .i_den        (7'(r_cnt)),
        .i_root_start (w_root_start),
        .i_rad        (r_min),
        .o_done       (w_dr_done),
        .o_res        (w_dr_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fcme_pkg::ST_IDLE:
                if (w_acc && (i_operation == fcme_pkg::OP_FACE)) n_state = fcme_pkg::ST_READ;
            fcme_pkg::ST_READ:
                n_state = fcme_pkg::ST_EDGE;
            fcme_pkg::ST_EDGE:
                if (!r_use_edge || (r_launched && w_sq_done))
                    n_state = r_last ? fcme_pkg::ST_CLOSE : fcme_pkg::ST_IDLE;
            fcme_pkg::ST_CLOSE:
                if (r_launched && w_sq_done) n_state = fcme_pkg::ST_DIV;
            fcme_pkg::ST_DIV:
                if (r_launched && w_dr_done && (r_axis == 2'd2)) n_state = fcme_pkg::ST_ROOT;
            fcme_pkg::ST_ROOT:
                if (r_launched && w_dr_done) n_state = fcme_pkg::ST_OUT;
            fcme_pkg::ST_OUT:
                if (w_out_free) n_state = fcme_pkg::ST_IDLE;
            default:
                n_state = fcme_pkg::ST_IDLE;
        endcase
    end

    // unit launches
    always_comb begin
        w_sq_start   = 1'b0;
        w_div_start  = 1'b0;
        w_root_start = 1'b0;
        case (r_state)
            fcme_pkg::ST_EDGE:  w_sq_start   = r_use_edge && !r_launched;
            fcme_pkg::ST_CLOSE: w_sq_start   = !r_launched;
            fcme_pkg::ST_DIV:   w_div_start  = !r_launched;
            fcme_pkg::ST_ROOT:  w_root_start = !r_launched;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fcme_pkg::ST_IDLE;
            r_launched <= 1'b0;
            r_axis     <= '0;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_min      <= '1;
            r_first    <= '0;
            r_prev     <= '0;
            r_use_edge <= 1'b0;
            o_valid    <= 1'b0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_launched <= 1'b0;
            else if (w_sq_start || w_div_start || w_root_start) r_launched <= 1'b1;
            if ((r_state == fcme_pkg::ST_OUT) && w_out_free) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                fcme_pkg::ST_IDLE: begin
                    if (w_acc) begin
                        r_valid_v <= w_inrange;
                        r_last    <= i_last_of_face;
                    end
                end
                fcme_pkg::ST_READ: begin
                    r_v <= r_valid_v ? w_rdata : w_zero;
                    r_use_edge <= (r_cnt != '0) && (r_cnt < CW'(MAX_FACE_VERTS));
                    if (r_cnt == '0) begin
                        r_first <= r_valid_v ? w_rdata : w_zero;
                        r_prev  <= r_valid_v ? w_rdata : w_zero;
                        r_sum[0] <= r_valid_v ? 40'(w_rdata.x) : '0;
                        r_sum[1] <= r_valid_v ? 40'(w_rdata.y) : '0;
                        r_sum[2] <= r_valid_v ? 40'(w_rdata.z) : '0;
                        r_cnt    <= CW'(1);
                    end else if (r_cnt >= CW'(MAX_FACE_VERTS)) begin
                        r_ovf <= 1'b1;
                    end
                end
                fcme_pkg::ST_EDGE: begin
                    if (r_use_edge && r_launched && w_sq_done) begin
                        if (w_sq < r_min) r_min <= w_sq;
                        r_prev   <= r_v;
                        r_sum[0] <= r_sum[0] + 40'(r_v.x);
                        r_sum[1] <= r_sum[1] + 40'(r_v.y);
                        r_sum[2] <= r_sum[2] + 40'(r_v.z);
                        r_cnt    <= r_cnt + CW'(1);
                    end
                    r_axis <= '0;
                end
                fcme_pkg::ST_CLOSE: begin
                    if (r_launched && w_sq_done && (w_sq < r_min)) r_min <= w_sq;
                end
                fcme_pkg::ST_DIV: begin
                    if (r_launched && w_dr_done) begin
                        case (r_axis)
                            2'd0:    r_res_x <= w_dr_res;
                            2'd1:    r_res_y <= w_dr_res;
                            default: r_res_z <= w_dr_res;
                        endcase
                        if (r_axis != 2'd2) begin
                            r_axis     <= r_axis + 2'd1;
                            r_launched <= 1'b0;
                        end
                    end
                end
                fcme_pkg::ST_ROOT: begin
                    if (r_launched && w_dr_done) r_res_len <= w_dr_res;
                end
                fcme_pkg::ST_OUT: begin
                    if (w_out_free) begin
                        o_center_x          <= r_res_x;
                        o_center_y          <= r_res_y;
                        o_center_z          <= r_res_z;
                        o_min_edge_length   <= r_res_len;
                        o_vertex_count      <= 5'(r_cnt);
                        o_too_many_vertices <= r_ovf;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_min   <= '1;
                        r_first <= '0;
                        r_prev  <= '0;
                        for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[tb/tb_face_centroid_min_edge_top.sv]
// testbench for face_centroid_min_edge_top: vertex loads and face walks checked against a predictor
`timescale 1ns / 1ps

module tb_face_centroid_min_edge_top;

    localparam int DEPTH      = 4096;
    localparam int MAX_VERTS  = 16;
    localparam int LIMIT      = 400000;
    localparam int HOLD_LEN   = 600;

    typedef struct {
        logic [31:0] cx, cy, cz, min_len;
        logic [4:0]  count;
        logic        too_many;
    } t_face_result;

    logic        i_clk, i_rst_n, i_valid, i_ready, i_last_of_face;
    logic        o_ready, o_valid, o_too_many_vertices;
    fcme_pkg::t_op i_operation;
    logic [12:0] i_vertex_index;
    logic signed [31:0] i_coord_x, i_coord_y, i_coord_z;
    logic signed [31:0] o_center_x, o_center_y, o_center_z;
    logic [31:0] o_min_edge_length;
    logic [4:0]  o_vertex_count;

    face_centroid_min_edge_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_vertex_index(i_vertex_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_last_of_face(i_last_of_face), .o_valid(o_valid), .i_ready(i_ready),
        .o_center_x(o_center_x), .o_center_y(o_center_y), .o_center_z(o_center_z),
        .o_min_edge_length(o_min_edge_length), .o_vertex_count(o_vertex_count),
        .o_too_many_vertices(o_too_many_vertices)
    );

    logic [31:0]  vert_x [DEPTH];
    logic [31:0]  vert_y [DEPTH];
    logic [31:0]  vert_z [DEPTH];
    int           loaded_idx[$];
    longint       first_v[3], prev_v[3], sum_v[3];
    bit [63:0]    min_sq;
    int           face_count;
    bit           face_overflow;
    t_face_result expected_faces[$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           idle_on;
    int           hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL face_centroid_min_edge_top");
            $finish;
        end
    end

    function automatic bit [63:0] edge_square(longint a[3], longint b[3]);
        bit [63:0] acc;
        bit [63:0] m;
        bit [64:0] s;
        longint    d;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            d = a[i] - b[i];
            m = (d < 0) ? -d : d;
            s = {1'b0, acc} + {1'b0, m * m};
            acc = s[64] ? '1 : s[63:0];
        end
        return acc;
    endfunction

    function automatic bit [31:0] root_floor(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[31:0];
    endfunction

    function automatic void clear_face();
        for (int i = 0; i < 3; i++) begin
            first_v[i] = 0;
            prev_v[i] = 0;
            sum_v[i] = 0;
        end
        min_sq = '1;
        face_count = 0;
        face_overflow = 0;
    endfunction

    function automatic void predict_beat(fcme_pkg::t_op op, int idx, logic [31:0] x,
                                         logic [31:0] y, logic [31:0] z, bit last);
        longint       v[3];
        bit [63:0]    sq;
        t_face_result r;
        bit           in_range;
        in_range = idx >= 1 && idx <= DEPTH;
        if (op == fcme_pkg::OP_LOAD) begin
            if (in_range) begin
                vert_x[idx-1] = x;
                vert_y[idx-1] = y;
                vert_z[idx-1] = z;
                loaded_idx.push_back(idx);
            end
            return;
        end
        v[0] = in_range ? longint'($signed(vert_x[idx-1])) : 0;
        v[1] = in_range ? longint'($signed(vert_y[idx-1])) : 0;
        v[2] = in_range ? longint'($signed(vert_z[idx-1])) : 0;
        if (face_count == 0) begin
            first_v = v;
            prev_v = v;
            sum_v = v;
            face_count = 1;
        end else if (face_count < MAX_VERTS) begin
            sq = edge_square(prev_v, v);
            if (sq < min_sq) min_sq = sq;
            for (int i = 0; i < 3; i++) sum_v[i] += v[i];
            prev_v = v;
            face_count++;
        end else begin
            face_overflow = 1;
        end
        if (!last) return;
        sq = edge_square(prev_v, first_v);
        if (sq < min_sq) min_sq = sq;
        r.cx = 32'(sum_v[0] / face_count);
        r.cy = 32'(sum_v[1] / face_count);
        r.cz = 32'(sum_v[2] / face_count);
        r.min_len = root_floor(min_sq);
        r.count = 5'(face_count);
        r.too_many = face_overflow;
        expected_faces.push_back(r);
        clear_face();
    endfunction

    task automatic send_beat(fcme_pkg::t_op op, int idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, bit last);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_vertex_index <= 13'(idx);
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        i_last_of_face <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_beat(op, idx, x, y, z, last);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic load_random(int idx);
        send_beat(fcme_pkg::OP_LOAD, idx, $urandom, $urandom, $urandom,
                  $urandom_range(0, 1));
    endtask

    task automatic face_random(int verts);
        int idx;
        for (int k = 0; k < verts; k++) begin
            if ($urandom_range(0, 19) == 0)
                idx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(DEPTH + 1, 8191);
            else
                idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
            send_beat(fcme_pkg::OP_FACE, idx, $urandom, $urandom, $urandom, k == verts - 1);
        end
    endtask

    task automatic wait_drained();
        while (expected_faces.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_beat(fcme_pkg::OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_beat(fcme_pkg::OP_LOAD, DEPTH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_beat(fcme_pkg::OP_LOAD, 2, 32'h0001_0000, 32'hffff_0000, 32'h0, 1'b0);
        send_beat(fcme_pkg::OP_LOAD, 3, 32'h0, 32'h0003_8000, 32'hfffe_0000, 1'b0);
        send_beat(fcme_pkg::OP_LOAD, 0, 32'h1234_5678, 32'h0, 32'h0, 1'b0);
        send_beat(fcme_pkg::OP_LOAD, 8191, 32'h0, 32'hdead_beef, 32'h0, 1'b1);
        // single vertex closes on itself
        send_beat(fcme_pkg::OP_FACE, DEPTH, 0, 0, 0, 1'b1);
        // saturating squared length
        send_beat(fcme_pkg::OP_FACE, 1, 0, 0, 0, 1'b0);
        send_beat(fcme_pkg::OP_FACE, DEPTH, 0, 0, 0, 1'b1);
        // out of range indices read zero
        send_beat(fcme_pkg::OP_FACE, 0, 0, 0, 0, 1'b0);
        send_beat(fcme_pkg::OP_FACE, 2, 0, 0, 0, 1'b0);
        send_beat(fcme_pkg::OP_FACE, 8191, 0, 0, 0, 1'b0);
        send_beat(fcme_pkg::OP_FACE, 3, 0, 0, 0, 1'b1);
        // too many vertices
        for (int k = 0; k < MAX_VERTS + 2; k++)
            send_beat(fcme_pkg::OP_FACE, 2 + (k % 2), 0, 0, 0, k == MAX_VERTS + 1);
        end_stream();
    endtask

    task automatic test_random();
        int n;
        int verts;
        n = 0;
        while (n < 360) begin
            if ($urandom_range(0, 4) == 0) begin
                load_random($urandom_range(0, 3) == 0 ? $urandom_range(1, DEPTH)
                                                      : $urandom_range(1, 64));
                n++;
            end else begin
                verts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20)
                                                    : $urandom_range(1, 5);
                face_random(verts);
                n += verts;
            end
        end
        end_stream();
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_req++;
        for (int f = 0; f < 6; f++) face_random($urandom_range(2, 4));
        end_stream();
    endtask

    task automatic test_sender_pause();
        face_random(3);
        end_stream();
        wait_drained();
        face_random(1);
        face_random(4);
        end_stream();
    endtask

    task automatic test_no_idle();
        wait_drained();
        idle_on = 0;
        for (int f = 0; f < 8; f++) face_random($urandom_range(1, 4));
        for (int k = 0; k < 4; k++) load_random($urandom_range(1, 64));
        end_stream();
    endtask

    initial begin
        int gap;
        int hold_left;
        int hold_seen;
        i_ready = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
                i_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_face_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_faces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
            end else begin
                e = expected_faces.pop_front();
                if (o_center_x !== e.cx || o_center_y !== e.cy || o_center_z !== e.cz ||
                    o_min_edge_length !== e.min_len || o_vertex_count !== e.count ||
                    o_too_many_vertices !== e.too_many) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h %0d %b got %h %h %h %h %0d %b",
                                 e.cx, e.cy, e.cz, e.min_len, e.count, e.too_many,
                                 o_center_x, o_center_y, o_center_z, o_min_edge_length,
                                 o_vertex_count, o_too_many_vertices);
                end
            end
        end
    end

    initial begin
        idle_on = 1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = fcme_pkg::OP_LOAD;
        i_vertex_index = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_last_of_face = 1'b0;
        clear_face();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        test_sender_pause();
        test_no_idle();
        wait_drained();
        if (mismatches == 0 && expected_faces.size() == 0)
            $display("PASS face_centroid_min_edge_top");
        else
            $display("FAIL face_centroid_min_edge_top");
        $finish;
    end

endmodule
